>>> src/pee_pkg.sv
// Shared types and constants of the prefix expression evaluator
`timescale 1ns / 1ps
package pee_pkg;

    localparam int STACK_DEPTH = 10;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef struct packed {
        logic load_item;
        logic pop;
        logic cap_x;
        logic cap_y;
        logic exec;
        logic div_init;
        logic div_step;
        logic div_fix;
        logic push;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_op;
        logic is_div;
        logic is_last;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

>>> src/pee_datapath.sv
// Datapath: stack memory, operand registers, ALU, iterative divider and output register
`timescale 1ns / 1ps
module pee_datapath
    import pee_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic                i_last,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [DATA_W-1:0]   o_value,
    output logic [2:0]          o_flags
);

    logic [DATA_W-1:0]    r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]    r_rd;
    logic                 r_empty;
    logic [CNT_W-1:0]     r_count;
    logic [SYM_W-1:0]     r_sym;
    logic                 r_last;
    logic [DATA_W-1:0]    r_x;
    logic [DATA_W-1:0]    r_y;
    logic [DATA_W-1:0]    r_res;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_ym;
    logic                 r_neg;
    logic                 r_zero;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_ovf;
    logic                 r_unf;
    logic                 r_dbz;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_value;
    logic [2:0]           r_out_flags;

    logic [DATA_W-1:0] popped;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic [CNT_W-1:0]  cnt_dec;
    logic              full;
    logic              out_free;

    assign popped   = r_empty ? EMPTY_VALUE : r_rd;
    assign rem_sh   = {r_rem, r_quo[DATA_W-1]};
    assign diff     = rem_sh - {1'b0, r_ym};
    assign cnt_dec  = r_count - CNT_W'(1);
    assign full     = (r_count == CNT_W'(STACK_DEPTH));
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.is_op    = (r_sym == SYM_ADD) || (r_sym == SYM_SUB) ||
                            (r_sym == SYM_MUL) || (r_sym == SYM_DIV);
        o_status.is_div   = (r_sym == SYM_DIV);
        o_status.is_last  = r_last;
        o_status.div_done = (r_div_cnt == DIV_CNT_W'(DATA_W - 1));
        o_status.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_mem[r_count[IDX_W-1:0]] <= r_res;
        end
        if (i_cmd.pop) begin
            r_rd <= r_mem[cnt_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_unf       <= 1'b0;
            r_dbz       <= 1'b0;
            r_out_valid <= 1'b0;
            r_empty     <= 1'b0;
            r_last      <= 1'b0;
            r_sym       <= '0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cmd.load_item) begin
                r_sym  <= i_symbol;
                r_last <= i_last;
            end
            if (i_cmd.pop) begin
                if (r_count == '0) begin
                    r_empty <= 1'b1;
                    r_unf   <= 1'b1;
                end else begin
                    r_empty <= 1'b0;
                    r_count <= cnt_dec;
                end
            end
            if (i_cmd.push) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.div_init) begin
                r_div_cnt <= '0;
                if (r_y == '0) begin
                    r_dbz <= 1'b1;
                end
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_unf       <= 1'b0;
                r_dbz       <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_res <= {{(DATA_W - SYM_W){1'b0}}, i_symbol} -
                     {{(DATA_W - SYM_W){1'b0}}, SYM_ZERO};
        end
        if (i_cmd.cap_x) begin
            r_x <= popped;
        end
        if (i_cmd.cap_y) begin
            r_y <= popped;
        end
        if (i_cmd.exec) begin
            unique case (r_sym)
                SYM_ADD: r_res <= r_x + r_y;
                SYM_SUB: r_res <= r_x - r_y;
                SYM_MUL: r_res <= r_x * r_y;
                default: r_res <= r_x;
            endcase
        end
        if (i_cmd.div_init) begin
            r_neg  <= r_x[DATA_W-1] ^ r_y[DATA_W-1];
            r_zero <= (r_y == '0);
            r_quo  <= r_x[DATA_W-1] ? (DATA_W'(0) - r_x) : r_x;
            r_ym   <= r_y[DATA_W-1] ? (DATA_W'(0) - r_y) : r_y;
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            if (!diff[DATA_W]) begin
                r_rem <= diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_fix) begin
            if (r_zero) begin
                r_res <= '0;
            end else if (r_neg) begin
                r_res <= DATA_W'(0) - r_quo;
            end else begin
                r_res <= r_quo;
            end
        end
        if (i_cmd.emit) begin
            r_out_value <= popped;
            r_out_flags <= {r_dbz, r_unf, r_ovf};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_flags     = r_out_flags;

endmodule

>>> src/pee_ctrl.sv
// Controller: sequences pops, arithmetic, division steps, pushes and result emission
`timescale 1ns / 1ps
module pee_ctrl
    import pee_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_POP_X    = 11'b00000000010,
        ST_POP_Y    = 11'b00000000100,
        ST_CAP_Y    = 11'b00000001000,
        ST_EXEC     = 11'b00000010000,
        ST_DIV_INIT = 11'b00000100000,
        ST_DIV_RUN  = 11'b00001000000,
        ST_DIV_FIX  = 11'b00010000000,
        ST_PUSH     = 11'b00100000000,
        ST_FIN_POP  = 11'b01000000000,
        ST_FIN_EMIT = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_POP_X;
                end
            end
            ST_POP_X: begin
                if (i_status.is_op) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_POP_Y;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state    = i_status.is_last ? ST_FIN_POP : ST_IDLE;
                end
            end
            ST_POP_Y: begin
                o_cmd.cap_x = 1'b1;
                o_cmd.pop   = 1'b1;
                n_state     = ST_CAP_Y;
            end
            ST_CAP_Y: begin
                o_cmd.cap_y = 1'b1;
                n_state     = i_status.is_div ? ST_DIV_INIT : ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_PUSH;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_DIV_FIX;
                end
            end
            ST_DIV_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = ST_PUSH;
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_status.is_last ? ST_FIN_POP : ST_IDLE;
            end
            ST_FIN_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = ST_FIN_EMIT;
            end
            ST_FIN_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/prefix_expression_evaluator_core.sv
// Top level of the stack-based prefix expression evaluator
`timescale 1ns / 1ps
// Characters of a prefix expression enter one word at a time, last character first, with
// tlast on the first character of the original string. A word is taken only while the
// controller is idle. A digit or other non-operator character is pushed; '+', '-' and
// '*' pop two operands, compute and push, and '/' does so through the 32-step restoring
// divider. The final character also pops and registers the result, waiting while the
// previous result has not yet been taken. The result leaves with the overflow, underflow
// and divide by zero flags of that expression, after which stack and flags are cleared.
module prefix_expression_evaluator_core
    import pee_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [SYM_W-1:0]  i_s_axis_tdata,   // [7:0] symbol
    input  logic              i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata,   // [31:0] value
    output logic [2:0]        o_m_axis_tuser    // [0] overflow_seen, [1] underflow_seen,
                                                // [2] divide_by_zero
);

    t_dp_cmd    cmd;
    t_dp_status status;

    pee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pee_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_symbol    (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_value     (o_m_axis_tdata),
        .o_flags     (o_m_axis_tuser)
    );

endmodule
